FILE: hdl/grbf_pkg.sv
// grbf_pkg: shared types, constants and state codes of the gaussian rbf evaluator
// used by every module under hdl but grbf_checker; depends on nothing
package grbf_pkg;

  localparam int unsigned DIV_STEPS  = 49;
  localparam int unsigned SQRT_STEPS = 24;
  localparam int unsigned EXP_TERMS  = 12;
  localparam int unsigned N_LIMIT    = 17;

  localparam logic [47:0] LN2_Q32 = 48'd2977044472;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] ADDR_ROOT_MODE = 2'd0;

  localparam logic [63:0] RECIP_ONE = 64'd1 << 36;

  // ceil(2^36 / k) for the horner divisors, exact floor for any 32-bit dividend
  function automatic logic [35:0] recip_q36(logic [3:0] k);
    case (k)
      4'd2:    recip_q36 = 36'((RECIP_ONE + 64'd1) / 64'd2);
      4'd3:    recip_q36 = 36'((RECIP_ONE + 64'd2) / 64'd3);
      4'd4:    recip_q36 = 36'((RECIP_ONE + 64'd3) / 64'd4);
      4'd5:    recip_q36 = 36'((RECIP_ONE + 64'd4) / 64'd5);
      4'd6:    recip_q36 = 36'((RECIP_ONE + 64'd5) / 64'd6);
      4'd7:    recip_q36 = 36'((RECIP_ONE + 64'd6) / 64'd7);
      4'd8:    recip_q36 = 36'((RECIP_ONE + 64'd7) / 64'd8);
      4'd9:    recip_q36 = 36'((RECIP_ONE + 64'd8) / 64'd9);
      4'd10:   recip_q36 = 36'((RECIP_ONE + 64'd9) / 64'd10);
      4'd11:   recip_q36 = 36'((RECIP_ONE + 64'd10) / 64'd11);
      4'd12:   recip_q36 = 36'((RECIP_ONE + 64'd11) / 64'd12);
      default: recip_q36 = '0;
    endcase
  endfunction

  // one queued coordinate, already squared
  typedef struct packed {
    logic [32:0] sq;
    logic [31:0] den;
    logic        wzero;
    logic        last;
    logic        mode;
  } grbf_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_ACC,
    S_SQRT,
    S_RED,
    S_HMUL,
    S_HQLO,
    S_HQHI,
    S_FIN
  } grbf_state_t;

endpackage

FILE: hdl/grbf_div.sv
// grbf_div: restoring divider, one quotient bit per cycle, 49-bit by 32-bit
// depends on grbf_pkg
module grbf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [48:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [48:0] quo_o
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [48:0] num_r;
  logic [48:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;

  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff_nxt;
  logic [31:0] rem_nxt;

  always_comb begin
    trial    = {rem_r, num_r[48]};
    ge       = trial >= {1'b0, den_r};
    diff_nxt = trial - {1'b0, den_r};
    rem_nxt  = ge ? diff_nxt[31:0] : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(grbf_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      num_r <= num_i;
      den_r <= den_i;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[47:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[47:0], ge};
    end
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

FILE: hdl/grbf_front.sv
// grbf_front: accepts coordinates, squares the difference, queues words for the back end
// depends on grbf_pkg
module grbf_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic signed [15:0]    in_coord,
  input  logic signed [15:0]    in_center,
  input  logic [15:0]           in_width,
  input  logic                  in_last_coord,
  input  logic                  root_mode_i,
  output logic                  item_valid_o,
  input  logic                  item_pop_i,
  output grbf_pkg::grbf_item_t  item_o
);

  grbf_pkg::grbf_item_t queue_r [2];
  logic [1:0] count_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;

  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic [33:0]        sq_full;
  logic [31:0]        wsq;
  logic               push_ok;
  logic               pop_ok;
  grbf_pkg::grbf_item_t item_new;

  always_comb begin
    diff    = {in_coord[15], in_coord} - {in_center[15], in_center};
    mag     = diff[16] ? 17'(-diff) : 17'(diff);
    sq_full = mag * mag;
    wsq     = in_width * in_width;
    item_new.sq    = sq_full[32:0];
    item_new.den   = root_mode_i ? wsq : {16'd0, in_width};
    item_new.wzero = (in_width == 16'd0);
    item_new.last  = in_last_coord;
    item_new.mode  = root_mode_i;
  end

  assign in_full      = (count_r == 2'd2);
  assign push_ok      = in_push && !in_full;
  assign item_valid_o = (count_r != 2'd0);
  assign pop_ok       = item_pop_i && item_valid_o;
  assign item_o       = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok)  rd_ptr_r <= ~rd_ptr_r;
      case ({push_ok, pop_ok})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) queue_r[wr_ptr_r] <= item_new;
  end

endmodule

FILE: hdl/grbf_back.sv
// grbf_back: divide, accumulate, square root and exponential sequencer with result register
// depends on grbf_pkg and grbf_div
module grbf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid_i,
  output logic                  item_pop_o,
  input  grbf_pkg::grbf_item_t  item_i,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [15:0]           out_rbf_value,
  output logic                  out_sum_saturated
);

  grbf_pkg::grbf_state_t state_r, state_nxt;
  grbf_pkg::grbf_item_t  entry_r;

  logic [31:0] acc_r;
  logic        sat_r;
  logic [47:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [4:0]  cnt_r;
  logic [47:0] r_r;
  logic [4:0]  n_r;
  logic [32:0] e_r;
  logic [31:0] p_r;
  logic [63:0] ql_r;
  logic [3:0]  k_r;
  logic        zero_r;
  logic        out_valid_r;
  logic [15:0] out_value_r;
  logic        out_sat_r;

  logic        div_start;
  logic [48:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [48:0] div_quo;
  logic        out_free;
  logic        out_load;

  grbf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // accumulate step
  logic        term_sat;
  logic [32:0] sum33;
  logic        sum_sat;
  logic [31:0] acc_nxt;

  always_comb begin
    term_sat = entry_r.wzero || (|div_quo[48:32]) || (&div_quo[31:0]);
    sum33    = {1'b0, acc_r} + {1'b0, div_quo[31:0]};
    sum_sat  = term_sat || sum33[32];
    acc_nxt  = sum_sat ? grbf_pkg::SUM_MAX : sum33[31:0];
  end

  // square root digit step
  logic [47:0] sq_trial;
  logic        sq_ge;
  logic [47:0] sq_v_nxt, sq_res_nxt;

  always_comb begin
    sq_trial   = sq_res_r + sq_bit_r;
    sq_ge      = sq_v_r >= sq_trial;
    sq_v_nxt   = sq_ge ? sq_v_r - sq_trial : sq_v_r;
    sq_res_nxt = sq_ge ? (sq_res_r >> 1) + sq_bit_r : sq_res_r >> 1;
  end

  // horner product, division by k through a reciprocal, final scaling
  logic [35:0] recip;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [35:0] hi_part;
  logic [67:0] hq_full;
  logic [31:0] hq_quo;
  logic [49:0] scaled;
  logic [49:0] shifted;
  logic [15:0] value_fin;
  logic [32:0] e_nxt;

  always_comb begin
    recip   = grbf_pkg::recip_q36(k_r);
    mul_a   = (state_r == grbf_pkg::S_HQLO) ? p_r : r_r[31:0];
    mul_b   = (state_r == grbf_pkg::S_HQLO) ? recip[31:0] : e_r[31:0];
    prod    = mul_a * mul_b;
    hi_part = {4'd0, p_r} * {32'd0, recip[35:32]};
    hq_full = {4'd0, ql_r} + {hi_part, 32'd0};
    // k of one needs no reciprocal
    hq_quo  = (k_r == 4'd1) ? p_r : hq_full[67:36];
    e_nxt   = grbf_pkg::ONE_Q32 - {1'b0, hq_quo};
    scaled  = ({17'd0, e_r} << 16) - {17'd0, e_r} + (50'd1 << (6'd31 + {1'b0, n_r}));
    shifted = scaled >> (6'd32 + {1'b0, n_r});
    if (zero_r) value_fin = 16'd0;
    else if (|shifted[49:16]) value_fin = 16'hFFFF;
    else value_fin = shifted[15:0];
  end

  assign out_free = !out_valid_r || out_pop;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      grbf_pkg::S_IDLE:   if (item_valid_i) state_nxt = grbf_pkg::S_LOAD;
      grbf_pkg::S_LOAD:   state_nxt = entry_r.wzero ? grbf_pkg::S_ACC : grbf_pkg::S_DIV;
      grbf_pkg::S_DIV:    if (div_done) state_nxt = grbf_pkg::S_ACC;
      grbf_pkg::S_ACC: begin
        if (!entry_r.last) state_nxt = grbf_pkg::S_IDLE;
        else if (entry_r.mode) state_nxt = grbf_pkg::S_SQRT;
        else state_nxt = grbf_pkg::S_RED;
      end
      grbf_pkg::S_SQRT:
        if (cnt_r == 5'(grbf_pkg::SQRT_STEPS - 1)) state_nxt = grbf_pkg::S_RED;
      grbf_pkg::S_RED: begin
        if (n_r == 5'(grbf_pkg::N_LIMIT)) state_nxt = grbf_pkg::S_FIN;
        else if (r_r < grbf_pkg::LN2_Q32) state_nxt = grbf_pkg::S_HMUL;
      end
      grbf_pkg::S_HMUL:   state_nxt = grbf_pkg::S_HQLO;
      grbf_pkg::S_HQLO:   state_nxt = grbf_pkg::S_HQHI;
      grbf_pkg::S_HQHI:   state_nxt = (k_r == 4'd1) ? grbf_pkg::S_FIN : grbf_pkg::S_HMUL;
      grbf_pkg::S_FIN:    if (out_free) state_nxt = grbf_pkg::S_IDLE;
      default:            state_nxt = grbf_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_pop_o = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    out_load   = 1'b0;
    case (state_r)
      grbf_pkg::S_IDLE: item_pop_o = item_valid_i;
      grbf_pkg::S_LOAD: begin
        div_start = !entry_r.wzero;
        div_num   = entry_r.mode ? {entry_r.sq, 16'd0} : {8'd0, entry_r.sq, 8'd0};
        div_den   = entry_r.den;
      end
      grbf_pkg::S_FIN: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grbf_pkg::S_IDLE;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == grbf_pkg::S_ACC) begin
        acc_r <= acc_nxt;
        sat_r <= sat_r | sum_sat;
      end
      if (out_load) begin
        acc_r       <= '0;
        sat_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      grbf_pkg::S_IDLE: if (item_valid_i) entry_r <= item_i;
      grbf_pkg::S_ACC: begin
        zero_r   <= 1'b0;
        sq_v_r   <= {acc_nxt, 16'd0};
        sq_res_r <= '0;
        sq_bit_r <= 48'd1 << 46;
        cnt_r    <= '0;
        r_r      <= {acc_nxt, 16'd0};
        n_r      <= '0;
      end
      grbf_pkg::S_SQRT: begin
        sq_v_r   <= sq_v_nxt;
        sq_res_r <= sq_res_nxt;
        sq_bit_r <= sq_bit_r >> 2;
        cnt_r    <= cnt_r + 5'd1;
        r_r      <= {sq_res_nxt[31:0], 16'd0};
      end
      grbf_pkg::S_RED: begin
        if (n_r == 5'(grbf_pkg::N_LIMIT)) begin
          zero_r <= 1'b1;
        end else if (r_r >= grbf_pkg::LN2_Q32) begin
          r_r <= r_r - grbf_pkg::LN2_Q32;
          n_r <= n_r + 5'd1;
        end else begin
          e_r <= grbf_pkg::ONE_Q32;
          k_r <= 4'(grbf_pkg::EXP_TERMS);
        end
      end
      grbf_pkg::S_HMUL: p_r <= e_r[32] ? r_r[31:0] : prod[63:32];
      grbf_pkg::S_HQLO: ql_r <= prod;
      grbf_pkg::S_HQHI: begin
        e_r <= e_nxt;
        k_r <= k_r - 4'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_value_r <= value_fin;
      out_sat_r   <= sat_r;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_rbf_value     = out_value_r;
  assign out_sum_saturated = out_sat_r;

endmodule

FILE: hdl/gaussian_rbf_evaluate_top.sv
// gaussian_rbf_evaluate_top: top level of the gaussian rbf evaluator
// depends on grbf_pkg, grbf_front, grbf_back
//
// input queue: one word per vector coordinate (coord, center, width, last_coord),
// taken when in_push is high and in_full is low. result queue: one word per vector,
// shown while out_empty is low and taken when out_pop is high.
// root_mode is written over the apb port at address 0 and sampled per coordinate.
// the front squares coord - center and holds up to two words; the back end runs a
// bit-serial 49-step divider for every coordinate of nonzero width, and it takes a new
// coordinate only when done with the last one. on the last coordinate range reduction
// subtracts ln2 n times (n up to 16, 17 when the result is zero) and the exponential
// runs 12 horner terms, each a product, a reciprocal multiply and an update; root mode
// adds a 24-step square root.
// the result register holds one word; while it is not taken the back end stops
// before its next result, and the front keeps taking words until its queue fills.
// reset empties both queues, clears the running sum and sets root_mode to 0.
module gaussian_rbf_evaluate_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_coord,
  input  logic signed [15:0] in_center,
  input  logic [15:0]        in_width,
  input  logic               in_last_coord,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [15:0]        out_rbf_value,
  output logic               out_sum_saturated,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic                 root_mode_r;
  logic                 item_valid;
  logic                 item_pop;
  grbf_pkg::grbf_item_t item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == grbf_pkg::ADDR_ROOT_MODE) begin
      root_mode_r <= cfg_pwdata[0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == grbf_pkg::ADDR_ROOT_MODE) ? {31'd0, root_mode_r} : 32'd0;

  grbf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_coord      (in_coord),
    .in_center     (in_center),
    .in_width      (in_width),
    .in_last_coord (in_last_coord),
    .root_mode_i   (root_mode_r),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop),
    .item_o        (item)
  );

  grbf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid_i      (item_valid),
    .item_pop_o        (item_pop),
    .item_i            (item),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_rbf_value     (out_rbf_value),
    .out_sum_saturated (out_sum_saturated)
  );

endmodule

FILE: hdl/grbf_checker.sv
// grbf_checker: port-level assertions for gaussian_rbf_evaluate_top, with its bind
// depends on gaussian_rbf_evaluate_top ports only
module grbf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_rbf_value,
  input logic        out_sum_saturated,
  input logic        cfg_pready
);

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // a waiting word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_rbf_value)))
    else $error("waiting result changed");

  // a saturated sum always drives the exponential to zero
  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_sum_saturated) |-> (out_rbf_value == 16'd0))
    else $error("saturated vector gave nonzero result");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind gaussian_rbf_evaluate_top grbf_checker u_grbf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_rbf_value     (out_rbf_value),
  .out_sum_saturated (out_sum_saturated),
  .cfg_pready        (cfg_pready)
);

FILE: bench/grbf_checker.sv
// grbf_scoreboard: watches the input, result and apb channels of the gaussian rbf evaluator,
// predicts every result word and compares it field by field
// depends on grbf_pkg for the register address and fixed-point constants
module grbf_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic signed [15:0] in_coord,
  input  logic signed [15:0] in_center,
  input  logic [15:0]        in_width,
  input  logic               in_last_coord,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [15:0]        out_rbf_value,
  input  logic               out_sum_saturated,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 rbf_pending,
  output int                 rbf_seen,
  output int                 sat_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] rbf_value;
    logic        sum_saturated;
  } rbf_word_t;

  rbf_word_t   rbf_expected[$];
  logic        mode_q;
  logic [31:0] dist_acc;
  logic        sat_flag;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] gauss_of(logic [31:0] d);
    logic [63:0] big, n, r, e, v, ln2, one;
    ln2 = 64'(grbf_pkg::LN2_Q32);
    one = 64'(grbf_pkg::ONE_Q32);
    big = {16'd0, d, 16'd0};
    n   = big / ln2;
    if (n > 16) return 16'd0;
    r = big - n * ln2;
    e = one;
    for (int k = int'(grbf_pkg::EXP_TERMS); k >= 1; k--) e = one - ((r * e) >> 32) / 64'(k);
    v = (e * 64'd65535 + (64'd1 << (31 + n))) >> (32 + n);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  assign rbf_pending = rbf_expected.size();

  always @(posedge clk) begin
    int          diff;
    logic [63:0] mag, sq, term, sum, w, dist_val;
    rbf_word_t   want;
    if (!rst_n) begin
      mode_q     <= 1'b0;
      dist_acc   = 0;
      sat_flag   = 0;
      fail_count <= 0;
      rbf_seen   <= 0;
      sat_seen   <= 0;
      rbf_expected.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == grbf_pkg::ADDR_ROOT_MODE)
        mode_q <= cfg_pwdata[0];

      if (in_push && !in_full) begin
        diff = int'(in_coord) - int'(in_center);
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        sq   = mag * mag;
        w    = 64'(in_width);
        if (w == 0) term = 64'(grbf_pkg::SUM_MAX);
        else if (mode_q) term = (sq << 16) / (w * w);
        else term = (sq << 8) / w;
        sum = 64'(dist_acc) + term;
        if (term >= 64'(grbf_pkg::SUM_MAX) || sum > 64'(grbf_pkg::SUM_MAX)) begin
          sum      = 64'(grbf_pkg::SUM_MAX);
          sat_flag = 1;
        end
        dist_acc = sum[31:0];
        if (in_last_coord) begin
          dist_val = mode_q ? int_sqrt({16'd0, dist_acc, 16'd0}) : 64'(dist_acc);
          want.rbf_value     = gauss_of(dist_val[31:0]);
          want.sum_saturated = sat_flag;
          rbf_expected.insert(rbf_expected.size(), want);
          if (sat_flag) sat_seen <= sat_seen + 1;
          dist_acc = 0;
          sat_flag = 0;
        end
      end

      if (out_pop && !out_empty) begin
        rbf_seen <= rbf_seen + 1;
        if (rbf_expected.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("[%0t] unexpected result word rbf=%0d sat=%0b", $realtime,
                     out_rbf_value, out_sum_saturated);
        end else begin
          want = rbf_expected.pop_front();
          if (want.rbf_value !== out_rbf_value || want.sum_saturated !== out_sum_saturated) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("[%0t] mismatch: expected rbf=%0d sat=%0b, got rbf=%0d sat=%0b",
                       $realtime, want.rbf_value, want.sum_saturated, out_rbf_value,
                       out_sum_saturated);
          end
        end
      end
    end
  end

endmodule

FILE: bench/gaussian_rbf_evaluate_top_tb.sv
// gaussian_rbf_evaluate_top_tb: drives coordinate words and root_mode writes into the
// gaussian rbf evaluator and gives the verdict; depends on grbf_pkg, grbf_scoreboard and
// gaussian_rbf_evaluate_top
module gaussian_rbf_evaluate_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic signed [15:0] in_coord;
  logic signed [15:0] in_center;
  logic [15:0]        in_width;
  logic               in_last_coord;
  logic               out_empty;
  logic               out_pop;
  logic [15:0]        out_rbf_value;
  logic               out_sum_saturated;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [1:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  int fail_count, rbf_pending, rbf_seen, sat_seen;
  int words_sent, vectors_sent, stall_cycles;
  bit hold_done;

  gaussian_rbf_evaluate_top u_top (.*);

  grbf_scoreboard u_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // sends one coordinate word; returns right after the edge that takes it
  task automatic send_coord(logic signed [15:0] c, logic signed [15:0] ctr,
                            logic [15:0] w, logic last);
    bit taken;
    @(negedge clk);
    in_push       <= 1'b1;
    in_coord      <= c;
    in_center     <= ctr;
    in_width      <= w;
    in_last_coord <= last;
    forever begin
      #1;
      taken = !in_full;
      @(posedge clk);
      if (taken) break;
      @(negedge clk);
    end
    words_sent++;
    if (last) vectors_sent++;
  endtask

  task automatic idle_sender();
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  task automatic write_root_mode(logic m);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= grbf_pkg::ADDR_ROOT_MODE;
    cfg_pwdata  <= {31'd0, m};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // block must be idle before root_mode changes
  task automatic drain();
    idle_sender();
    wait (rbf_pending == 0);
    repeat (800) @(posedge clk);
  endtask

  task automatic directed_vectors();
    send_coord(16'sh7FFF, 16'sh8000, 16'd1, 1'b1);     // largest distance, narrowest width
    send_coord(16'sd0, 16'sd0, 16'd256, 1'b1);         // zero distance
    send_coord(16'sh1234, 16'sh1234, 16'hFFFF, 1'b0);
    send_coord(16'sh0100, 16'sh0000, 16'hFFFF, 1'b1);
    send_coord(16'sh0040, 16'sh0000, 16'd0, 1'b1);      // zero width saturates
    send_coord(16'sh8000, 16'sh7FFF, 16'h0100, 1'b0);   // sum overflow mid vector
    send_coord(16'sh8000, 16'sh7FFF, 16'h0100, 1'b0);
    send_coord(16'sh0000, 16'sh0000, 16'h0100, 1'b1);
    send_coord(16'sh0180, 16'sh0000, 16'h0100, 1'b1);   // coordinate 1.5 widths from the center
    send_coord(16'sh0100, 16'sh0000, 16'h0100, 1'b0);
    send_coord(16'shFF00, 16'sh0000, 16'h0200, 1'b1);
    send_coord(16'sh0001, 16'sh0000, 16'h0001, 1'b1);
  endtask

  task automatic random_vectors(int count);
    int len;
    logic signed [15:0] c, ctr;
    logic [15:0] w;
    int sent;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        ctr = 16'($urandom);
        if ($urandom_range(0, 9) < 7) c = ctr + 16'($signed($urandom_range(0, 1023)) - 512);
        else c = 16'($urandom);
        case ($urandom_range(0, 9))
          0:       w = 16'($urandom);
          1:       w = (i == 0 && $urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 255));
          default: w = 16'($urandom_range(256, 4095));
        endcase
        // a word occupies the block until its divide is done, so gaps are long
        if ((words_sent < 700 || words_sent >= 1000) && $urandom_range(0, 99) < 10) begin
          repeat ($urandom_range(20, 90)) idle_sender();
        end
        send_coord(c, ctr, w, i == len - 1);
        sent++;
      end
    end
  endtask

  // result side: random pops, a steady run of pops, one long hold-off while the sender keeps going
  initial begin
    out_pop = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && rbf_seen >= 60) begin
        hold_done = 1;
        out_pop <= 1'b0;
        repeat (4000) @(negedge clk);
        out_pop <= 1'b1;
      end else if (rbf_seen >= 200 && rbf_seen < 260) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_coord      = '0;
    in_center     = '0;
    in_width      = '0;
    in_last_coord = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    words_sent    = 0;
    vectors_sent  = 0;
    hold_done     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_root_mode(1'b0);
    directed_vectors();
    drain();
    write_root_mode(1'b1);
    directed_vectors();
    random_vectors(380);
    drain();
    write_root_mode(1'b0);
    random_vectors(400);
    drain();
    write_root_mode(1'b1);
    random_vectors(380);
    drain();
    write_root_mode(1'b0);
    random_vectors(370);
    drain();

    $display("sent %0d coordinate words in %0d vectors over both modes", words_sent,
             vectors_sent);
    $display("checked %0d result words, %0d of them with a saturated sum", rbf_seen, sat_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
